// ----- rtl/ioe_pkg.sv -----
package ioe_pkg;

  // One instruction as it arrives on the command channel.
  typedef struct packed {
    logic [15:0] opcode;
    logic [1:0]  op_class;
    logic        allows_immediate;
    logic [1:0]  operand_size;
    logic [3:0]  addr_mode;
    logic        indirect;
    logic [2:0]  index_reg;
    logic [15:0] operand_value;
    logic        value_absolute;
  } cmd_t;

  // One instruction byte as it leaves on the result channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] reloc_kind;
    logic       error_code;
    logic       last;
  } res_t;

  // Longest instruction: prefix, opcode, postbyte and a 16-bit operand.
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  // Classified instruction as it waits between the front and the back end.
  typedef struct packed {
    logic                        err;
    logic [CntW-1:0]             count;
    logic [MaxBytes-1:0][7:0]    bytes;
    logic [MaxBytes-1:0][1:0]    relocs;
  } entry_t;

  // Depth of the queue between the two ends.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAW    = $clog2(QDepth);

  // Instruction classes.
  localparam logic [1:0] CLS_HIGH = 2'd0;
  localparam logic [1:0] CLS_LOW  = 2'd1;
  localparam logic [1:0] CLS_JSR  = 2'd2;
  localparam logic [1:0] CLS_LEA  = 2'd3;

  // Operand size codes.
  localparam logic [1:0] SIZE_BYTE = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Addressing modes.
  localparam logic [3:0] MODE_IMM  = 4'd0;
  localparam logic [3:0] MODE_DIR  = 4'd1;
  localparam logic [3:0] MODE_EXT  = 4'd2;
  localparam logic [3:0] MODE_OFS  = 4'd3;
  localparam logic [3:0] MODE_PI1  = 4'd4;
  localparam logic [3:0] MODE_PI2  = 4'd5;
  localparam logic [3:0] MODE_PD1  = 4'd6;
  localparam logic [3:0] MODE_PD2  = 4'd7;
  localparam logic [3:0] MODE_ACCA = 4'd8;
  localparam logic [3:0] MODE_ACCB = 4'd9;
  localparam logic [3:0] MODE_ACCD = 4'd10;

  // Index register code for PC relative addressing.
  localparam logic [2:0] REG_PC = 3'd4;

  // Relocation kinds.
  localparam logic [1:0] RELOC_NONE  = 2'd0;
  localparam logic [1:0] RELOC_SEG   = 2'd1;
  localparam logic [1:0] RELOC_PCREL = 2'd2;

  // Result codes.
  localparam logic ERR_OK   = 1'b0;
  localparam logic ERR_FORM = 1'b1;

  // Postbyte values.
  localparam logic [7:0] PB_PCR8     = 8'h8C;
  localparam logic [7:0] PB_PCR16    = 8'h8D;
  localparam logic [7:0] PB_PCR8_IND = 8'h9C;
  localparam logic [7:0] PB_PCR16_IND = 8'h9D;
  localparam logic [7:0] PB_ZERO     = 8'h84;
  localparam logic [7:0] PB_ZERO_IND = 8'h94;
  localparam logic [7:0] PB_OFS8     = 8'h88;
  localparam logic [7:0] PB_OFS8_IND = 8'h98;
  localparam logic [7:0] PB_OFS16    = 8'h89;
  localparam logic [7:0] PB_OFS16_IND = 8'h99;
  localparam logic [7:0] PB_EXT_IND  = 8'h9F;
  localparam logic [7:0] PB_PI1      = 8'h80;
  localparam logic [7:0] PB_PI2      = 8'h81;
  localparam logic [7:0] PB_PI2_IND  = 8'h91;
  localparam logic [7:0] PB_PD1      = 8'h82;
  localparam logic [7:0] PB_PD2      = 8'h83;
  localparam logic [7:0] PB_PD2_IND  = 8'h93;
  localparam logic [7:0] PB_ACCA     = 8'h86;
  localparam logic [7:0] PB_ACCA_IND = 8'h96;
  localparam logic [7:0] PB_ACCB     = 8'h85;
  localparam logic [7:0] PB_ACCB_IND = 8'h95;
  localparam logic [7:0] PB_ACCD     = 8'h8B;
  localparam logic [7:0] PB_ACCD_IND = 8'h9B;
  localparam logic [7:0] PB_OFS5_MSK = 8'h1F;

endpackage

// ----- rtl/ioe_front.sv -----
module ioe_front (
  input  ioe_pkg::cmd_t   cmd_i,
  output ioe_pkg::entry_t entry_o
);

  logic       word;
  logic       ok;
  logic       postform;
  logic       has_prefix;
  logic       fits5;
  logic       fits8;
  logic [7:0] adj;
  logic [7:0] vh;
  logic [7:0] vl;
  logic [7:0] rsel;
  logic [1:0] rk;
  logic [15:0] pcw;
  logic [7:0] t0, t1, t2;
  logic [1:0] k1, k2;
  logic [1:0] tn;
  logic [7:0] opb;

  // Legality check of the class, mode, register and size combination.
  always_comb begin
    word = (cmd_i.op_class == ioe_pkg::CLS_HIGH) ?
           (cmd_i.operand_size != ioe_pkg::SIZE_BYTE) : 1'b1;
    ok   = 1'b1;
    if (cmd_i.addr_mode > ioe_pkg::MODE_ACCD) begin
      ok = 1'b0;
    end else if (cmd_i.addr_mode <= ioe_pkg::MODE_DIR) begin
      if (cmd_i.indirect) ok = 1'b0;
      if (cmd_i.addr_mode == ioe_pkg::MODE_IMM &&
          !(cmd_i.op_class == ioe_pkg::CLS_HIGH && cmd_i.allows_immediate)) ok = 1'b0;
      if (cmd_i.op_class == ioe_pkg::CLS_LEA) ok = 1'b0;
    end else if (cmd_i.addr_mode == ioe_pkg::MODE_EXT) begin
      if (cmd_i.op_class == ioe_pkg::CLS_LEA) ok = 1'b0;
    end else begin
      if (cmd_i.index_reg > ioe_pkg::REG_PC) ok = 1'b0;
      if (cmd_i.addr_mode >= ioe_pkg::MODE_PI1 && cmd_i.index_reg == ioe_pkg::REG_PC) begin
        ok = 1'b0;
      end
      if (cmd_i.op_class == ioe_pkg::CLS_LEA &&
          (cmd_i.indirect || (cmd_i.addr_mode >= ioe_pkg::MODE_PI1 &&
                              cmd_i.addr_mode <= ioe_pkg::MODE_PD2))) ok = 1'b0;
      if (cmd_i.indirect && (cmd_i.addr_mode == ioe_pkg::MODE_PI1 ||
                             cmd_i.addr_mode == ioe_pkg::MODE_PD1)) ok = 1'b0;
      if ((cmd_i.addr_mode == ioe_pkg::MODE_PI1 || cmd_i.addr_mode == ioe_pkg::MODE_PD1) &&
          word) ok = 1'b0;
      if ((cmd_i.addr_mode == ioe_pkg::MODE_PI2 || cmd_i.addr_mode == ioe_pkg::MODE_PD2) &&
          !word) ok = 1'b0;
    end
  end

  // Opcode adjustment for the addressing form.
  always_comb begin
    postform = (cmd_i.addr_mode >= ioe_pkg::MODE_OFS) ||
               (cmd_i.addr_mode == ioe_pkg::MODE_EXT && cmd_i.indirect);
    adj = 8'h00;
    case (cmd_i.op_class)
      ioe_pkg::CLS_HIGH: begin
        if (cmd_i.addr_mode == ioe_pkg::MODE_IMM) adj = 8'h00;
        else if (cmd_i.addr_mode == ioe_pkg::MODE_DIR) adj = 8'h10;
        else if (postform) adj = 8'h20;
        else adj = 8'h30;
      end
      ioe_pkg::CLS_LOW: begin
        if (cmd_i.addr_mode == ioe_pkg::MODE_DIR) adj = 8'h00;
        else if (postform) adj = 8'h60;
        else adj = 8'h70;
      end
      ioe_pkg::CLS_JSR: begin
        if (cmd_i.addr_mode == ioe_pkg::MODE_DIR) adj = 8'h00;
        else if (postform) adj = 8'h10;
        else adj = 8'h20;
      end
      default: adj = 8'h00;
    endcase
    opb        = cmd_i.opcode[7:0] + adj;
    has_prefix = (cmd_i.op_class != ioe_pkg::CLS_LEA) && (cmd_i.opcode[15:8] != 8'h00);
  end

  // Postbyte and operand bytes that follow the opcode.
  always_comb begin
    vh    = cmd_i.operand_value[15:8];
    vl    = cmd_i.operand_value[7:0];
    rk    = cmd_i.value_absolute ? ioe_pkg::RELOC_NONE : ioe_pkg::RELOC_SEG;
    rsel  = {1'b0, cmd_i.index_reg[1:0], 5'b00000};
    fits5 = (cmd_i.operand_value[15:4] == 12'h000) || (cmd_i.operand_value[15:4] == 12'hFFF);
    fits8 = (cmd_i.operand_value[15:7] == 9'h000) || (cmd_i.operand_value[15:7] == 9'h1FF);
    pcw   = cmd_i.operand_value - 16'd2;
    t0 = 8'h00;
    t1 = 8'h00;
    t2 = 8'h00;
    k1 = ioe_pkg::RELOC_NONE;
    k2 = ioe_pkg::RELOC_NONE;
    tn = 2'd0;
    unique case (cmd_i.addr_mode)
      ioe_pkg::MODE_IMM: begin
        if (word) begin
          t0 = vh; t1 = vl; tn = 2'd2;
        end else begin
          t0 = vl; tn = 2'd1;
        end
      end
      ioe_pkg::MODE_DIR: begin
        t0 = vl; tn = 2'd1;
      end
      ioe_pkg::MODE_EXT: begin
        if (cmd_i.indirect) begin
          t0 = ioe_pkg::PB_EXT_IND; t1 = vh; t2 = vl; k1 = rk; k2 = rk; tn = 2'd3;
        end else begin
          t0 = vh; t1 = vl; tn = 2'd2;
        end
      end
      ioe_pkg::MODE_OFS: begin
        if (cmd_i.index_reg == ioe_pkg::REG_PC) begin
          if (cmd_i.value_absolute && fits8) begin
            t0 = cmd_i.indirect ? ioe_pkg::PB_PCR8_IND : ioe_pkg::PB_PCR8;
            t1 = vl; tn = 2'd2;
          end else if (cmd_i.value_absolute) begin
            t0 = cmd_i.indirect ? ioe_pkg::PB_PCR16_IND : ioe_pkg::PB_PCR16;
            t1 = vh; t2 = vl; tn = 2'd3;
          end else begin
            t0 = cmd_i.indirect ? ioe_pkg::PB_PCR16_IND : ioe_pkg::PB_PCR16;
            t1 = pcw[15:8]; t2 = pcw[7:0];
            k1 = ioe_pkg::RELOC_PCREL; k2 = ioe_pkg::RELOC_PCREL; tn = 2'd3;
          end
        end else if (cmd_i.value_absolute && cmd_i.operand_value == 16'h0000) begin
          t0 = (cmd_i.indirect ? ioe_pkg::PB_ZERO_IND : ioe_pkg::PB_ZERO) | rsel;
          tn = 2'd1;
        end else if (cmd_i.value_absolute && !cmd_i.indirect && fits5) begin
          t0 = rsel | (vl & ioe_pkg::PB_OFS5_MSK);
          tn = 2'd1;
        end else if (cmd_i.value_absolute && fits8) begin
          t0 = (cmd_i.indirect ? ioe_pkg::PB_OFS8_IND : ioe_pkg::PB_OFS8) | rsel;
          t1 = vl; tn = 2'd2;
        end else begin
          t0 = (cmd_i.indirect ? ioe_pkg::PB_OFS16_IND : ioe_pkg::PB_OFS16) | rsel;
          t1 = vh; t2 = vl; k1 = rk; k2 = rk; tn = 2'd3;
        end
      end
      ioe_pkg::MODE_PI1: begin
        t0 = ioe_pkg::PB_PI1 | rsel; tn = 2'd1;
      end
      ioe_pkg::MODE_PI2: begin
        t0 = (cmd_i.indirect ? ioe_pkg::PB_PI2_IND : ioe_pkg::PB_PI2) | rsel; tn = 2'd1;
      end
      ioe_pkg::MODE_PD1: begin
        t0 = ioe_pkg::PB_PD1 | rsel; tn = 2'd1;
      end
      ioe_pkg::MODE_PD2: begin
        t0 = (cmd_i.indirect ? ioe_pkg::PB_PD2_IND : ioe_pkg::PB_PD2) | rsel; tn = 2'd1;
      end
      ioe_pkg::MODE_ACCA: begin
        t0 = (cmd_i.indirect ? ioe_pkg::PB_ACCA_IND : ioe_pkg::PB_ACCA) | rsel; tn = 2'd1;
      end
      ioe_pkg::MODE_ACCB: begin
        t0 = (cmd_i.indirect ? ioe_pkg::PB_ACCB_IND : ioe_pkg::PB_ACCB) | rsel; tn = 2'd1;
      end
      default: begin
        t0 = (cmd_i.indirect ? ioe_pkg::PB_ACCD_IND : ioe_pkg::PB_ACCD) | rsel; tn = 2'd1;
      end
    endcase
    // Immediate, direct and plain extended operands take the operand's relocation kind, segment unless absolute.
    if (cmd_i.addr_mode <= ioe_pkg::MODE_DIR ||
        (cmd_i.addr_mode == ioe_pkg::MODE_EXT && !cmd_i.indirect)) begin
      k1 = rk;
      k2 = rk;
    end
  end

  // Byte list of the entry, or a single error beat.
  always_comb begin
    entry_o = '0;
    if (!ok) begin
      entry_o.err   = ioe_pkg::ERR_FORM;
      entry_o.count = ioe_pkg::CntW'(1);
    end else if (has_prefix) begin
      entry_o.err    = ioe_pkg::ERR_OK;
      entry_o.count  = ioe_pkg::CntW'(tn) + ioe_pkg::CntW'(2);
      entry_o.bytes  = {t2, t1, t0, opb, cmd_i.opcode[15:8]};
      entry_o.relocs = {k2, k1, ((cmd_i.addr_mode <= ioe_pkg::MODE_DIR ||
                         (cmd_i.addr_mode == ioe_pkg::MODE_EXT && !cmd_i.indirect))
                         ? rk : ioe_pkg::RELOC_NONE),
                        ioe_pkg::RELOC_NONE, ioe_pkg::RELOC_NONE};
    end else begin
      entry_o.err    = ioe_pkg::ERR_OK;
      entry_o.count  = ioe_pkg::CntW'(tn) + ioe_pkg::CntW'(1);
      entry_o.bytes  = {8'h00, t2, t1, t0, opb};
      entry_o.relocs = {ioe_pkg::RELOC_NONE, k2, k1,
                        ((cmd_i.addr_mode <= ioe_pkg::MODE_DIR ||
                         (cmd_i.addr_mode == ioe_pkg::MODE_EXT && !cmd_i.indirect))
                         ? rk : ioe_pkg::RELOC_NONE),
                        ioe_pkg::RELOC_NONE};
    end
  end

endmodule

// ----- rtl/ioe_queue.sv -----
module ioe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ioe_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output ioe_pkg::entry_t head_o
);

  localparam logic [ioe_pkg::QAW-1:0] LastPtr = ioe_pkg::QAW'(ioe_pkg::QDepth - 1);

  ioe_pkg::entry_t                   slot_q [ioe_pkg::QDepth];
  logic [ioe_pkg::QAW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [ioe_pkg::QAW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [ioe_pkg::QAW:0]             cnt_q, cnt_d;

  assign full_o  = (cnt_q == (ioe_pkg::QAW + 1)'(ioe_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/ioe_back.sv -----
module ioe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  ioe_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            valid_o,
  output ioe_pkg::res_t   res_o
);

  logic [ioe_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     valid_q, valid_d;
  ioe_pkg::res_t            res_q, res_d;
  logic                     is_last;

  assign is_last = (idx_q == ioe_pkg::IdxW'(head_i.count - ioe_pkg::CntW'(1)));
  assign pop_o   = !empty_i && is_last;

  // Step through the bytes of the head entry, one beat per cycle while the queue is not empty.
  always_comb begin
    idx_d   = idx_q;
    valid_d = !empty_i;
    res_d.out_byte   = head_i.bytes[idx_q];
    res_d.reloc_kind = head_i.relocs[idx_q];
    res_d.error_code = head_i.err;
    res_d.last       = is_last;
    if (!empty_i) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output register for the result beat.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/indexed_operand_encoder.sv -----
// Channel   Direction  Handshake            Payload
// command   in         start / busy         cmd_i  (ioe_pkg::cmd_t)
// result    out        valid_o strobe       res_o  (ioe_pkg::res_t)
//
// An instruction gives one to five result beats, one per cycle. A taken command
// is written into a two-entry queue between the classifier and the byte
// sequencer in the back end; its beats leave through the sequencer's output
// register. The sequencer sets the rate: it sends every byte of one instruction
// before the next. Busy rises only when the queue holds two instructions. Reset
// clears the queue, the sequencer and the strobe. The receiver cannot stall.
module indexed_operand_encoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ioe_pkg::cmd_t cmd_i,
  output logic          valid_o,
  output ioe_pkg::res_t res_o
);

  ioe_pkg::entry_t entry;
  ioe_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  assign busy = full;
  assign push = start && !full;

  // Classifier.
  ioe_front u_front (
    .cmd_i   (cmd_i),
    .entry_o (entry)
  );

  // Queue between the two ends.
  ioe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // Byte sequencer.
  ioe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule
